// File: rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer: channel
// payloads, item kinds and default sizes.
// ----------------------------------------------------------------------------
package hcbp_pkg;

   // Default sizes handed to the top level's parameters
   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int SYMBOL_COUNT_DEF = 256;

   // Entries in the queue between front and back end
   localparam int QUEUE_DEPTH = 4;

   // Bits in one packed output byte
   localparam int BYTE_W = 8;

   // Item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  symbol;
      logic [31:0] code_bits;
      logic [5:0]  code_length;
   } hcbp_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } hcbp_rsp_type;

endpackage

// File: rtl/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front
// Front end: takes input items, writes code table entries, looks up the
// code of a data byte and hands data and flush operations to the queue.
// ----------------------------------------------------------------------------
module hcbp_front import hcbp_pkg::*; #(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
   parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
   parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hcbp_req_type            req_data,
   output logic                    op_valid,
   input  logic                    op_ready,
   output logic                    op_flush,
   output logic [LEN_W-1:0]        op_len,
   output logic [MAX_CODE_LEN-1:0] op_code
);

   localparam int IDX_W   = $clog2(SYMBOL_COUNT);
   localparam int ENTRY_W = MAX_CODE_LEN + LEN_W;

   // Code and length per symbol; lengths count only where the loaded bit is set
   logic [ENTRY_W-1:0]      tbl_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] loaded_ff, loaded_in;
   logic [ENTRY_W-1:0]      rd_ff;
   logic                    hit_ff;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_flush_ff;

   logic                    accept;
   logic                    sym_ok;
   logic [IDX_W-1:0]        idx;
   logic                    wr_en;
   logic                    is_op;
   logic [LEN_W-1:0]        len_sat;
   logic [MAX_CODE_LEN+31:0] code_wide;
   logic [LEN_W-1:0]        s1_len;
   logic [MAX_CODE_LEN-1:0] s1_code;

   assign sym_ok    = {1'b0, req_data.symbol} < 9'(SYMBOL_COUNT);
   assign idx       = req_data.symbol[IDX_W-1:0];
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (req_data.kind == KIND_LOAD) && sym_ok;
   assign is_op     = ((req_data.kind == KIND_DATA) && sym_ok) || (req_data.kind == KIND_FLUSH);

   // Saturate the loaded length; code positions beyond the 32 given bits read as zero
   assign len_sat   = (req_data.code_length > 6'(MAX_CODE_LEN)) ?
                      LEN_W'(MAX_CODE_LEN) : req_data.code_length[LEN_W-1:0];
   assign code_wide = {{MAX_CODE_LEN{1'b0}}, req_data.code_bits};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[idx] <= {code_wide[MAX_CODE_LEN-1:0], len_sat};
      end
      if (accept) begin
         rd_ff  <= tbl_mem[idx];
         hit_ff <= loaded_ff[idx];
      end
   end

   always_comb begin
      loaded_in = loaded_ff;
      if (wr_en) begin
         loaded_in[idx] = 1'b1;
      end
   end

   assign s1_len  = hit_ff ? rd_ff[LEN_W-1:0] : '0;
   assign s1_code = rd_ff[ENTRY_W-1:LEN_W];

   // Zero-length lookups give no operation and are dropped here
   assign op_valid  = s1_valid_ff && (s1_flush_ff || (s1_len != '0));
   assign op_flush  = s1_flush_ff;
   assign op_len    = s1_len;
   assign op_code   = s1_code << (LEN_W'(MAX_CODE_LEN) - s1_len);
   assign req_stall = op_valid && !op_ready;

   assign s1_valid_in = req_stall ? s1_valid_ff : (accept && is_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         loaded_ff   <= loaded_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flush_ff <= (req_data.kind == KIND_FLUSH);
      end
   end

endmodule

// File: rtl/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue
// Short first-in first-out queue of operations between front and back end.
// ----------------------------------------------------------------------------
module hcbp_queue import hcbp_pkg::*; #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back
// Back end: appends code words to the bit accumulator and sends complete
// bytes, one per cycle unless rsp stalls, through the output register.
// ----------------------------------------------------------------------------
module hcbp_back import hcbp_pkg::*; #(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
   parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    op_valid,
   output logic                    op_ready,
   input  logic                    op_flush,
   input  logic [LEN_W-1:0]        op_len,
   input  logic [MAX_CODE_LEN-1:0] op_code,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hcbp_rsp_type            rsp_data
);

   localparam int BUF_W = MAX_CODE_LEN + BYTE_W;
   localparam int TOT_W = $clog2(MAX_CODE_LEN + BYTE_W);

   // Pending bits sit at the top of the buffer; everything below is zero
   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic             rsp_valid_ff, rsp_valid_in;
   hcbp_rsp_type     rsp_data_ff;

   logic             out_free;
   logic             emit;
   logic [TOT_W-1:0] rem;
   logic [BUF_W-1:0] base;
   logic             take;
   logic [BUF_W-1:0] code_ext;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (total_ff >= TOT_W'(BYTE_W)) && out_free;
   assign rem      = emit ? total_ff - TOT_W'(BYTE_W) : total_ff;
   assign base     = emit ? buf_ff << BYTE_W : buf_ff;
   assign op_ready = rem < TOT_W'(BYTE_W);
   assign take     = op_valid && op_ready;
   assign code_ext = {op_code, {BYTE_W{1'b0}}} >> rem[2:0];

   always_comb begin
      buf_in   = base;
      total_in = rem;
      if (take) begin
         if (op_flush) begin
            // A partial byte goes out as a full one padded with zeros
            total_in = (rem != '0) ? TOT_W'(BYTE_W) : '0;
         end else begin
            buf_in   = base | code_ext;
            total_in = rem + TOT_W'(op_len);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff.out_byte <= buf_ff[BUF_W-1 -: BYTE_W];
         rsp_data_ff.last     <= rem < TOT_W'(BYTE_W);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman bit packer: code table load, code lookup and MSB-first packing
// of code words into bytes, with flush of a trailing partial byte.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload          transfer when
//   req      in         hcbp_req_type    req_valid high, req_stall low
//   rsp      out        hcbp_rsp_type    rsp_valid high, rsp_stall low
//
// The front end takes one item per cycle while req is not stalled. A data
// item is registered with its table read and reaches the queue once the
// read is back. The back end takes a new queued operation only while less
// than a byte of bits is pending, so an item that completes several bytes
// holds the queue; each byte passes from the accumulator register into the
// output register. Loads, zero-length symbols, out-of-range symbols and
// kind 3 never enter the queue.
// Reset clears the table's loaded bits, the accumulator and all handshake
// state at once; no clearing pass is needed.
// A stall on rsp holds the output register; the queue then fills and stalls
// req once its entries are in use.
//
module huffman_code_bit_packer import hcbp_pkg::*; #(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
   parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  hcbp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output hcbp_rsp_type rsp_data
);

   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
   localparam int OP_W  = 1 + LEN_W + MAX_CODE_LEN;

   // Front end towards the queue
   logic                    f_valid, f_ready, f_flush;
   logic [LEN_W-1:0]        f_len;
   logic [MAX_CODE_LEN-1:0] f_code;

   // Queue towards the back end
   logic                    b_valid, b_ready;
   logic [OP_W-1:0]         b_op;

   hcbp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .LEN_W        (LEN_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .op_valid  (f_valid),
      .op_ready  (f_ready),
      .op_flush  (f_flush),
      .op_len    (f_len),
      .op_code   (f_code)
   );

   // Queue operations so a stall at one end blocks the other only once full
   hcbp_queue #(
      .WIDTH (OP_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_flush, f_len, f_code}),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_op)
   );

   hcbp_back #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .LEN_W        (LEN_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (b_valid),
      .op_ready  (b_ready),
      .op_flush  (b_op[OP_W-1]),
      .op_len    (b_op[OP_W-2 -: LEN_W]),
      .op_code   (b_op[MAX_CODE_LEN-1:0]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/hcbp_props.sv
// ----------------------------------------------------------------------------
// hcbp_props
// Port-level properties of the Huffman code bit packer, bound to the top.
// ----------------------------------------------------------------------------
module hcbp_props import hcbp_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input hcbp_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input hcbp_rsp_type rsp_data
);

   // A stalled request stays offered with its payload unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("req_data changed while stalled");

   // A byte waiting on a stall stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A byte waiting on a stall keeps its value and marker
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // No byte is offered straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Front end is free straight out of reset
   a_req_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_stall)
      else $error("req_stall high after reset");

endmodule

bind huffman_code_bit_packer hcbp_props u_props (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Huffman code bit packer. A queue of load, data,
// flush and ignored items feeds a falling-edge driver; every accepted item
// updates a local copy of the code table and byte accumulator, which predicts
// the packed bytes. A rising-edge monitor compares each output transfer with
// the oldest predicted byte. Both sides idle at random, and the receiver holds
// off once for a long stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top import hcbp_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // Kind value the block must ignore
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam int RANDOM_ITEMS = 350;
   localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 20;    // settle time after the last byte
   localparam int TIMEOUT_NS   = 500000;

   typedef struct {
      hcbp_req_type item;
      int unsigned  gap;    // idle cycles after this item's transfer
   } send_entry_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   hcbp_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   hcbp_rsp_type rsp_data;

   // Items waiting to be offered, and bytes predicted but not yet seen
   send_entry_type items_to_send[$];
   hcbp_rsp_type   bytes_due[$];

   // Predictor state: code table, length table and byte accumulator
   logic [31:0]  tbl_code [SYMBOL_COUNT_DEF];
   logic [5:0]   tbl_len  [SYMBOL_COUNT_DEF];
   logic [7:0]   acc_byte = '0;
   int unsigned  acc_fill = 0;

   // Transfer bookkeeping shared between processes
   int unsigned  items_offered = 0;
   int unsigned  items_taken   = 0;
   int unsigned  bytes_seen    = 0;
   int unsigned  bytes_paced   = 0;
   int unsigned  failures      = 0;
   int unsigned  input_stalled = 0;
   int unsigned  send_gap      = 0;
   int unsigned  rsp_wait      = 0;
   bit           rsp_calm      = 1'b0;
   bit           rsp_hold      = 1'b0;

   // Generator bookkeeping: only symbols already loaded are ever looked up
   bit           sym_written [SYMBOL_COUNT_DEF];
   logic [7:0]   written_syms[$];
   bit           sender_calm   = 1'b0;
   int unsigned  n_loads = 0, n_data = 0, n_flush = 0, n_ignored = 0;

   hcbp_rsp_type want;

   huffman_code_bit_packer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Work out the bytes one accepted item produces and queue them in order,
   // marking the final one of the item.
   task automatic predict_bytes(input hcbp_req_type it);
      logic [7:0]  made [5];
      int unsigned cnt;
      int unsigned len;
      hcbp_rsp_type r;
      cnt = 0;
      case (it.kind)
         KIND_LOAD: begin
            len = it.code_length;
            if (len > MAX_CODE_LEN_DEF) len = MAX_CODE_LEN_DEF;  // saturate long codes
            tbl_code[it.symbol] = it.code_bits;
            tbl_len[it.symbol]  = len[5:0];
         end
         KIND_DATA: begin
            // Append code bits MSB first; bits above the length never enter
            for (int i = tbl_len[it.symbol]; i > 0; i--) begin
               if (i - 1 < 32 && tbl_code[it.symbol][i - 1]) acc_byte[7 - acc_fill] = 1'b1;
               acc_fill++;
               if (acc_fill == 8) begin
                  made[cnt] = acc_byte;
                  cnt++;
                  acc_byte = '0;
                  acc_fill = 0;
               end
            end
         end
         KIND_FLUSH: begin
            // Only a non-empty accumulator produces a padded byte
            if (acc_fill > 0) begin
               made[cnt] = acc_byte;
               cnt++;
               acc_byte = '0;
               acc_fill = 0;
            end
         end
         default: ;
      endcase
      for (int k = 0; k < cnt; k++) begin
         r.out_byte = made[k];
         r.last     = (k == cnt - 1);
         bytes_due.push_back(r);
      end
   endtask

   function automatic hcbp_req_type make_item(logic [1:0] k, logic [7:0] s,
                                               logic [31:0] b, logic [5:0] l);
      hcbp_req_type it;
      it.kind        = k;
      it.symbol      = s;
      it.code_bits   = b;
      it.code_length = l;
      return it;
   endfunction

   // Queue an item for the driver with its idle gap; track which symbols
   // have a table entry so that data never reads an unwritten one.
   task automatic queue_item(input hcbp_req_type it);
      send_entry_type e;
      if ($urandom_range(0, 24) == 0) sender_calm = ~sender_calm;
      e.item = it;
      e.gap  = sender_calm ? 0 : $urandom_range(0, 10);
      items_to_send.push_back(e);
      case (it.kind)
         KIND_LOAD: begin
            n_loads++;
            if (!sym_written[it.symbol]) begin
               sym_written[it.symbol] = 1'b1;
               written_syms.push_back(it.symbol);
            end
         end
         KIND_DATA:  n_data++;
         KIND_FLUSH: n_flush++;
         default:    n_ignored++;
      endcase
   endtask

   function automatic logic [5:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return 6'd0;
         1:       return 6'($urandom_range(33, 63));   // over the limit, saturates
         2, 3:    return 6'($urandom_range(13, 32));
         default: return 6'($urandom_range(1, 12));
      endcase
   endfunction

   // Monitor: sample both channels at the rising edge. An input transfer
   // advances the predictor; an output transfer is checked against the
   // oldest predicted byte.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall) input_stalled++;
         if (req_valid && !req_stall) begin
            predict_bytes(req_data);
            items_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            bytes_seen++;
            if (bytes_due.size() == 0) begin
               $error("out_byte: expected none, got %02h", rsp_data.out_byte);
               failures++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_data.out_byte);
                  failures++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  failures++;
               end
            end
         end
      end
   end

   // Driver: change the request side at the falling edge. Drop valid after
   // a transfer unless the next item follows with no gap, so valid is
   // assigned once per edge.
   always @(negedge clock) begin : drive_req
      logic           next_valid;
      send_entry_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && items_taken == items_offered) next_valid = 1'b0;
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (items_to_send.size() > 0) begin
               nxt = items_to_send.pop_front();
               req_data <= nxt.item;
               send_gap = nxt.gap;
               items_offered++;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: draw a wait for every byte, with calm stretches of none,
   // and hold off completely while the long pressure stretch is on.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (bytes_seen != bytes_paced) begin
            bytes_paced = bytes_seen;
            if ($urandom_range(0, 29) == 0) rsp_calm = ~rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 10);
         end
         if (rsp_hold) begin
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Pressure: partway through the random part, hold the output for a
   // long stretch while the sender keeps offering items.
   initial begin
      while (items_taken < 60) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      logic [1:0] k;
      logic [7:0] s;
      for (int i = 0; i < SYMBOL_COUNT_DEF; i++) begin
         tbl_code[i]    = '0;
         tbl_len[i]     = '0;
         sym_written[i] = 1'b0;
      end

      // Directed part: extremes, every kind and each special case
      queue_item(make_item(KIND_LOAD, 8'h00, 32'h0000_0001, 6'd1));
      queue_item(make_item(KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32));
      queue_item(make_item(KIND_LOAD, 8'h5A, 32'hDEAD_BEEF, 6'd0));   // zero length
      queue_item(make_item(KIND_LOAD, 8'hA5, 32'h8000_0001, 6'd63));  // saturates to 32
      queue_item(make_item(KIND_LOAD, 8'h3C, 32'hFFFF_FF55, 6'd7));   // high bits ignored
      queue_item(make_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0));          // flush when empty
      queue_item(make_item(KIND_DATA, 8'h00, 32'h0, 6'd0));
      queue_item(make_item(KIND_DATA, 8'hFF, 32'hFFFF_FFFF, 6'd63));  // one bit held, 4 bytes out
      queue_item(make_item(KIND_DATA, 8'h5A, 32'h0, 6'd0));           // emits nothing
      queue_item(make_item(KIND_DATA, 8'hA5, 32'h0, 6'd0));
      queue_item(make_item(KIND_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63)); // pads partial byte
      queue_item(make_item(KIND_DATA, 8'h3C, 32'h0, 6'd0));
      queue_item(make_item(KIND_DATA, 8'h00, 32'h0, 6'd0));           // completes a byte
      queue_item(make_item(KIND_IGNORED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
      queue_item(make_item(KIND_LOAD, 8'h3C, 32'h0000_0000, 6'd8));   // reload an entry
      queue_item(make_item(KIND_DATA, 8'h3C, 32'h0, 6'd0));
      queue_item(make_item(KIND_DATA, 8'hFF, 32'h0, 6'd0));
      queue_item(make_item(KIND_DATA, 8'h00, 32'h0, 6'd0));
      queue_item(make_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0));
      queue_item(make_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0));          // second flush is empty
      queue_item(make_item(KIND_LOAD, 8'h81, 32'h0000_0000, 6'd33));
      queue_item(make_item(KIND_DATA, 8'h81, 32'h0, 6'd0));

      // Random part: mostly lookups of loaded symbols, with loads, flushes
      // and ignored kinds mixed in
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 99))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: k = KIND_LOAD;
            12, 13, 14, 15, 16, 17, 18, 19, 20:   k = KIND_FLUSH;
            21, 22, 23:                           k = KIND_IGNORED;
            default:                              k = KIND_DATA;
         endcase
         if (k == KIND_DATA) begin
            s = written_syms[$urandom_range(0, written_syms.size() - 1)];
            queue_item(make_item(KIND_DATA, s, $urandom, 6'($urandom_range(0, 63))));
         end else if (k == KIND_LOAD) begin
            queue_item(make_item(KIND_LOAD, 8'($urandom_range(0, 255)), $urandom,
                                 pick_length()));
         end else begin
            queue_item(make_item(k, 8'($urandom_range(0, 255)), $urandom,
                                 6'($urandom_range(0, 63))));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Hold until every item has been transferred and every byte seen
      while (items_to_send.size() > 0 || req_valid) @(posedge clock);
      while (bytes_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d loads, %0d lookups, %0d flushes, %0d ignored.",
               items_taken, n_loads, n_data, n_flush, n_ignored);
      $display("Checked %0d packed bytes; input held off for %0d cycles.",
               bytes_seen, input_stalled);
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/hcbp_pkg.sv
rtl/hcbp_front.sv
rtl/hcbp_queue.sv
rtl/hcbp_back.sv
rtl/huffman_code_bit_packer.sv
rtl/hcbp_props.sv
tb/sv/tb_top.sv
